// ===== rtl/core/lbst_pkg.sv =====
// shared constants for the complex four-vector lorentz boost
package lbst_pkg;

    // stream layout
    localparam int COMP_W    = 32;
    localparam int BETA_W    = 18;
    localparam int NUM_COMP  = 8;
    localparam int NUM_BETA  = 3;
    localparam int IN_BITS   = NUM_COMP * COMP_W + NUM_BETA * BETA_W;
    localparam int S_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int M_DATA_W  = NUM_COMP * COMP_W;

    // velocity magnitude, Q.34
    localparam int SQ_W      = 35;
    localparam int SUM_W     = 36;
    localparam int D_W       = 35;
    localparam logic [SUM_W-1:0] ONE_Q34 = SUM_W'(1) << 34;
    localparam int ARG_SHIFT = 28;

    // root, gamma and g1
    localparam int SQRT_IN_W   = 64;
    localparam int ROOT_W      = SQRT_IN_W / 2;
    localparam int G_W         = 48;
    localparam int G_INIT_EXP  = 13;
    localparam int DEN2_W      = 49;
    localparam int Q2_W        = 30;
    localparam int Q2_INIT_EXP = 30;
    localparam logic [DEN2_W-1:0] TWO30 = DEN2_W'(1) << 30;

    // products and accumulation
    localparam int MUL_LAT    = 4;
    localparam int PROD_W     = COMP_W + BETA_W;
    localparam int P_W        = PROD_W + 2;
    localparam int TP_W       = PROD_W + 3;
    localparam int H_W        = G_W + 1;
    localparam int HPROD_W    = H_W + BETA_W + 1;
    localparam int ACC_W      = 104;
    localparam int FRAC_SHIFT = 47;

    localparam logic [COMP_W-1:0] OUT_MAX = {1'b0, {(COMP_W-1){1'b1}}};
    localparam logic [COMP_W-1:0] OUT_MIN = {1'b1, {(COMP_W-1){1'b0}}};

endpackage

// ===== rtl/core/lbst_delay.sv =====
// fixed-depth delay line that advances with the pipeline enable
module lbst_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);
    logic [W-1:0] dly_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            dly_reg[0] <= din;
            for (int k = 1; k < DEPTH; k++) begin
                dly_reg[k] <= dly_reg[k-1];
            end
        end
    end

    assign dout = dly_reg[DEPTH-1];
endmodule

// ===== rtl/core/lbst_mul.sv =====
// pipelined signed multiplier built from four 32x32 partial products
module lbst_mul #(
    parameter int A_W = lbst_pkg::COMP_W,
    parameter int B_W = lbst_pkg::COMP_W
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic signed [A_W-1:0]       a,
    input  logic signed [B_W-1:0]       b,
    output logic signed [A_W+B_W-1:0]   p
);
    import lbst_pkg::*;

    localparam int PW = A_W + B_W;

    logic [A_W-1:0]   a_abs;
    logic [B_W-1:0]   b_abs;
    logic [63:0]      ma_reg, mb_reg;
    logic             sign1_reg, sign2_reg, sign3_reg;
    logic [63:0]      pp_reg [4];
    logic [127:0]     mag_reg, mag_next;
    logic signed [PW-1:0] p_reg;

    always_comb begin
        a_abs = a[A_W-1] ? A_W'(~a + 1'b1) : A_W'(a);
        b_abs = b[B_W-1] ? B_W'(~b + 1'b1) : B_W'(b);
        mag_next = 128'(pp_reg[0]) + 128'({pp_reg[1], 32'b0})
                 + 128'({pp_reg[2], 32'b0}) + {pp_reg[3], 64'b0};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ma_reg    <= 64'(a_abs);
            mb_reg    <= 64'(b_abs);
            sign1_reg <= a[A_W-1] ^ b[B_W-1];
            pp_reg[0] <= ma_reg[31:0] * mb_reg[31:0];
            pp_reg[1] <= ma_reg[31:0] * mb_reg[63:32];
            pp_reg[2] <= ma_reg[63:32] * mb_reg[31:0];
            pp_reg[3] <= ma_reg[63:32] * mb_reg[63:32];
            sign2_reg <= sign1_reg;
            mag_reg   <= mag_next;
            sign3_reg <= sign2_reg;
            p_reg     <= signed'(PW'(sign3_reg ? (~mag_reg + 128'd1) : mag_reg));
        end
    end

    assign p = p_reg;
endmodule

// ===== rtl/core/lbst_sqrt.sv =====
// pipelined integer square root, one root bit per stage
module lbst_sqrt #(
    parameter int IN_W = lbst_pkg::SQRT_IN_W
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [IN_W-1:0]   radicand,
    output logic [IN_W/2-1:0] root
);
    import lbst_pkg::*;

    localparam int STEPS = IN_W / 2;
    localparam int REM_W = STEPS + 2;

    logic [IN_W-1:0]  n_reg    [STEPS];
    logic [STEPS-1:0] root_reg [STEPS];
    logic [REM_W-1:0] rem_reg  [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [IN_W-1:0]  n_in;
        logic [STEPS-1:0] root_in;
        logic [REM_W-1:0] rem_in, rem_sh, trial;

        if (k == 0) begin : g_first
            assign n_in    = radicand;
            assign root_in = '0;
            assign rem_in  = '0;
        end else begin : g_next
            assign n_in    = n_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rem_in  = rem_reg[k-1];
        end

        assign rem_sh = {rem_in[REM_W-3:0], n_in[IN_W-1 -: 2]};
        assign trial  = {root_in, 2'b01};

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[k] <= n_in << 2;
                if (rem_sh >= trial) begin
                    rem_reg[k]  <= rem_sh - trial;
                    root_reg[k] <= {root_in[STEPS-2:0], 1'b1};
                end else begin
                    rem_reg[k]  <= rem_sh;
                    root_reg[k] <= {root_in[STEPS-2:0], 1'b0};
                end
            end
        end
    end

    assign root = root_reg[STEPS-1];
endmodule

// ===== rtl/core/lbst_div.sv =====
// pipelined restoring divider of a power of two by a variable, one bit per stage
module lbst_div #(
    parameter int DEN_W    = lbst_pkg::ROOT_W,
    parameter int QUO_W    = lbst_pkg::G_W,
    parameter int INIT_EXP = lbst_pkg::G_INIT_EXP
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [DEN_W-1:0] divisor,
    output logic [QUO_W-1:0] quotient
);
    import lbst_pkg::*;

    // numerator bits above the quotient range leave exactly this remainder
    localparam logic [DEN_W-1:0] REM_INIT = DEN_W'(1) << INIT_EXP;

    logic [DEN_W-1:0] rem_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic [DEN_W-1:0] rem_in, den_in;
        logic [QUO_W-1:0] quo_in;
        logic [DEN_W:0]   rem_sh;

        if (k == 0) begin : g_first
            assign rem_in = REM_INIT;
            assign den_in = divisor;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign rem_sh = {rem_in, 1'b0};

        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[k] <= den_in;
                if (rem_sh >= {1'b0, den_in}) begin
                    rem_reg[k] <= DEN_W'(rem_sh - {1'b0, den_in});
                    quo_reg[k] <= {quo_in[QUO_W-2:0], 1'b1};
                end else begin
                    rem_reg[k] <= DEN_W'(rem_sh);
                    quo_reg[k] <= {quo_in[QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    assign quotient = quo_reg[QUO_W-1];
endmodule

// ===== rtl/core/complex_four_vector_lorentz_boost.sv =====
// top level: pipelined general lorentz boost of a complex four-vector
//
//  channel | dir | fields (lowest bits first)
//  s_      | in  | tdata: comp_x_re, comp_x_im, comp_y_re, comp_y_im, comp_z_re,
//          |     |        comp_z_im, comp_t_re, comp_t_im, beta_x, beta_y, beta_z
//  m_      | out | tdata: out_x_re .. out_t_im   tuser: superluminal
//
// one vector per cycle while the output is not stalled; the latency is set by the pipelined square root
// (32 stages) and the two reciprocal dividers (48 and 30 stages) in series.
// aresetn clears only the valid bits; data registers are not reset.
// the pipeline advances whenever the output register is free or the last
// stage holds a bubble, so input transfers go on while a result waits.
module complex_four_vector_lorentz_boost (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lbst_pkg::S_DATA_W-1:0]  s_tdata,   // x_re,x_im,y_re,y_im,z_re,z_im,t_re,t_im,bx,by,bz
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lbst_pkg::M_DATA_W-1:0]  m_tdata,   // x_re,x_im,y_re,y_im,z_re,z_im,t_re,t_im
    output logic [0:0]                     m_tuser    // superluminal
);
    import lbst_pkg::*;

    localparam int T_IN  = 1;
    localparam int T_ARG = 3;
    localparam int T_R   = T_ARG + ROOT_W;
    localparam int T_G   = T_R + G_W;
    localparam int T_Q2  = T_G + Q2_W;
    localparam int T_G1  = T_Q2 + 1;
    localparam int T_H   = T_G1 + MUL_LAT + 1;
    localparam int T_ACC = T_H + MUL_LAT + 2;
    localparam int DLY3_W = P_W + TP_W + NUM_BETA * PROD_W;

    logic core_en, out_en;
    logic [T_ACC:T_IN] vld_reg, vld_next;
    logic m_tvalid_reg;

    assign out_en   = !m_tvalid_reg || m_tready;
    assign core_en  = out_en || !vld_reg[T_ACC];
    assign s_tready = core_en;
    assign m_tvalid = m_tvalid_reg;
    assign vld_next = {vld_reg[T_ACC-1:T_IN], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (core_en) vld_reg <= vld_next;
            if (out_en) m_tvalid_reg <= vld_reg[T_ACC];
        end
    end

    // input register and squares of the velocity
    logic [IN_BITS-1:0]       in_reg;
    logic signed [BETA_W-1:0] b_in [NUM_BETA];
    logic signed [2*BETA_W-1:0] sq_full [NUM_BETA];
    logic [SQ_W-1:0]          sq_reg [NUM_BETA];
    logic [SUM_W-1:0]         s_sum;
    logic                     sl_next, sl_reg;
    logic [D_W-1:0]           d_next;
    logic [SQRT_IN_W-1:0]     arg_reg;

    always_comb begin
        for (int i = 0; i < NUM_BETA; i++) begin
            b_in[i]    = signed'(in_reg[NUM_COMP*COMP_W + i*BETA_W +: BETA_W]);
            sq_full[i] = b_in[i] * b_in[i];
        end
        s_sum   = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        sl_next = s_sum >= ONE_Q34;
        d_next  = sl_next ? D_W'(1) : D_W'(ONE_Q34 - s_sum);
    end

    always_ff @(posedge aclk) begin
        if (core_en) begin
            in_reg <= s_tdata[IN_BITS-1:0];
            for (int i = 0; i < NUM_BETA; i++) sq_reg[i] <= sq_full[i][SQ_W-1:0];
            sl_reg  <= sl_next;
            arg_reg <= {1'b0, d_next, ARG_SHIFT'(0)};
        end
    end

    // gamma = 2^61 / sqrt(d * 2^28), g1 = gamma - 2^30 + 2^60 / (gamma + 2^30)
    logic [ROOT_W-1:0] root_w;
    logic [G_W-1:0]    g_w, g_dly_w, g1_reg, g114_reg, g119_w;
    logic [DEN2_W-1:0] den2_w;
    logic [Q2_W-1:0]   q2_w;

    lbst_sqrt #(.IN_W(SQRT_IN_W)) u_sqrt (
        .aclk(aclk), .en(core_en), .radicand(arg_reg), .root(root_w)
    );

    lbst_div #(.DEN_W(ROOT_W), .QUO_W(G_W), .INIT_EXP(G_INIT_EXP)) u_div_gamma (
        .aclk(aclk), .en(core_en), .divisor(root_w), .quotient(g_w)
    );

    assign den2_w = DEN2_W'(g_w) + TWO30;

    lbst_div #(.DEN_W(DEN2_W), .QUO_W(Q2_W), .INIT_EXP(Q2_INIT_EXP)) u_div_g1 (
        .aclk(aclk), .en(core_en), .divisor(den2_w), .quotient(q2_w)
    );

    lbst_delay #(.W(G_W), .DEPTH(Q2_W)) u_dly_g (
        .aclk(aclk), .en(core_en), .din(g_w), .dout(g_dly_w)
    );

    always_ff @(posedge aclk) begin
        if (core_en) begin
            g1_reg   <= g_dly_w - G_W'(TWO30) + G_W'(q2_w);
            g114_reg <= g_dly_w;
        end
    end

    lbst_delay #(.W(G_W), .DEPTH(T_H - T_G1)) u_dly_g2 (
        .aclk(aclk), .en(core_en), .din(g114_reg), .dout(g119_w)
    );

    // vector and velocity brought level with g1
    logic [IN_BITS-1:0]       vb_w;
    logic signed [COMP_W-1:0] v114 [NUM_COMP];
    logic signed [BETA_W-1:0] b114 [NUM_BETA];
    logic [BETA_W-1:0]        bmag [NUM_BETA];
    logic [NUM_BETA-1:0]      bsign114, bsign118;

    lbst_delay #(.W(IN_BITS), .DEPTH(T_G1 - T_IN)) u_dly_vb (
        .aclk(aclk), .en(core_en), .din(in_reg), .dout(vb_w)
    );

    always_comb begin
        for (int k = 0; k < NUM_COMP; k++) v114[k] = signed'(vb_w[k*COMP_W +: COMP_W]);
        for (int i = 0; i < NUM_BETA; i++) begin
            b114[i]     = signed'(vb_w[NUM_COMP*COMP_W + i*BETA_W +: BETA_W]);
            bsign114[i] = b114[i][BETA_W-1];
            bmag[i]     = bsign114[i] ? BETA_W'(~b114[i] + 1'b1) : BETA_W'(b114[i]);
        end
    end

    lbst_delay #(.W(NUM_BETA), .DEPTH(MUL_LAT)) u_dly_sign (
        .aclk(aclk), .en(core_en), .din(bsign114), .dout(bsign118)
    );

    // h_i = g1 * b_i, truncated toward zero
    logic signed [HPROD_W-1:0] hprod [NUM_BETA];
    logic signed [H_W-1:0]     h_reg [NUM_BETA];

    for (genvar i = 0; i < NUM_BETA; i++) begin : g_h
        lbst_mul #(.A_W(H_W), .B_W(BETA_W + 1)) u_mul_h (
            .aclk(aclk), .en(core_en),
            .a(signed'({1'b0, g1_reg})), .b(signed'({1'b0, bmag[i]})), .p(hprod[i])
        );

        always_ff @(posedge aclk) begin
            if (core_en) begin
                h_reg[i] <= bsign118[i]
                    ? signed'(H_W'(~{1'b0, hprod[i][G_W+16:17]} + 1'b1))
                    : signed'({1'b0, hprod[i][G_W+16:17]});
            end
        end
    end

    // dot product b.v and b_i*t, per real and imaginary part
    logic signed [PROD_W-1:0] pv_reg [2][NUM_BETA];
    logic signed [PROD_W-1:0] bt_reg [2][NUM_BETA];
    logic signed [PROD_W-1:0] bt116_reg [2][NUM_BETA];
    logic signed [COMP_W-1:0] t115_reg [2];
    logic signed [P_W-1:0]    p_reg [2];
    logic signed [TP_W-1:0]   tp_reg [2];
    logic signed [P_W-1:0]    p_sum [2];
    logic signed [PROD_W-2:0] t_sh [2];

    always_comb begin
        for (int pt = 0; pt < 2; pt++) begin
            p_sum[pt] = P_W'(pv_reg[pt][0]) + P_W'(pv_reg[pt][1]) + P_W'(pv_reg[pt][2]);
            t_sh[pt]  = signed'({t115_reg[pt], 17'b0});
        end
    end

    always_ff @(posedge aclk) begin
        if (core_en) begin
            for (int pt = 0; pt < 2; pt++) begin
                for (int i = 0; i < NUM_BETA; i++) begin
                    pv_reg[pt][i]    <= b114[i] * v114[2*i + pt];
                    bt_reg[pt][i]    <= b114[i] * v114[6 + pt];
                    bt116_reg[pt][i] <= bt_reg[pt][i];
                end
                t115_reg[pt] <= v114[6 + pt];
                p_reg[pt]    <= p_sum[pt];
                tp_reg[pt]   <= TP_W'(t_sh[pt]) + TP_W'(p_sum[pt]);
            end
        end
    end

    // final products: g*b_i*t, h_i*(b.v), g*(t + b.v)
    logic signed [TP_W-1:0]       tp119 [2];
    logic signed [P_W-1:0]        p119 [2];
    logic signed [PROD_W-1:0]     bt119 [2][NUM_BETA];
    logic signed [H_W+PROD_W-1:0] gbt [2][NUM_BETA];
    logic signed [H_W+P_W-1:0]    hp [2][NUM_BETA];
    logic signed [H_W+TP_W-1:0]   gt [2];
    logic signed [ACC_W-1:0]      sum1_reg [2][NUM_BETA];
    logic signed [ACC_W-1:0]      gt124_reg [2];

    for (genvar pt = 0; pt < 2; pt++) begin : g_part
        logic [DLY3_W-1:0] pd_in, pd_out;

        assign pd_in = {bt116_reg[pt][2], bt116_reg[pt][1], bt116_reg[pt][0],
                        tp_reg[pt], p_reg[pt]};

        lbst_delay #(.W(DLY3_W), .DEPTH(T_H - T_G1 - 2)) u_dly_p (
            .aclk(aclk), .en(core_en), .din(pd_in), .dout(pd_out)
        );

        assign p119[pt]  = signed'(pd_out[P_W-1:0]);
        assign tp119[pt] = signed'(pd_out[P_W +: TP_W]);

        lbst_mul #(.A_W(H_W), .B_W(TP_W)) u_mul_gt (
            .aclk(aclk), .en(core_en),
            .a(signed'({1'b0, g119_w})), .b(tp119[pt]), .p(gt[pt])
        );

        for (genvar i = 0; i < NUM_BETA; i++) begin : g_axis
            assign bt119[pt][i] = signed'(pd_out[P_W + TP_W + i*PROD_W +: PROD_W]);

            lbst_mul #(.A_W(H_W), .B_W(PROD_W)) u_mul_gbt (
                .aclk(aclk), .en(core_en),
                .a(signed'({1'b0, g119_w})), .b(bt119[pt][i]), .p(gbt[pt][i])
            );

            lbst_mul #(.A_W(H_W), .B_W(P_W)) u_mul_hp (
                .aclk(aclk), .en(core_en),
                .a(h_reg[i]), .b(p119[pt]), .p(hp[pt][i])
            );
        end
    end

    // accumulate in q.47, then floor shift and saturate; superluminal inputs pass through unchanged
    logic [M_DATA_W-1:0]       v124_w;
    logic [M_DATA_W-1:0]       v125_reg;
    logic                      sl125_w;
    logic signed [ACC_W-1:0]   acc_reg [NUM_COMP];
    logic signed [ACC_W-1:0]   acc_next [NUM_COMP];
    logic signed [COMP_W+FRAC_SHIFT-1:0] v_sh [NUM_COMP];
    logic [M_DATA_W-1:0]       m_data_next, m_data_reg;
    logic                      m_user_reg;
    logic                      sat_hi, sat_lo;

    lbst_delay #(.W(M_DATA_W), .DEPTH(T_ACC - 1 - T_G1)) u_dly_v (
        .aclk(aclk), .en(core_en), .din(vb_w[M_DATA_W-1:0]), .dout(v124_w)
    );

    lbst_delay #(.W(1), .DEPTH(T_ACC - T_ARG)) u_dly_sl (
        .aclk(aclk), .en(core_en), .din(sl_reg), .dout(sl125_w)
    );

    always_comb begin
        for (int k = 0; k < NUM_COMP; k++) begin
            v_sh[k] = signed'({v124_w[k*COMP_W +: COMP_W], FRAC_SHIFT'(0)});
        end
        for (int pt = 0; pt < 2; pt++) begin
            for (int i = 0; i < NUM_BETA; i++) begin
                acc_next[2*i + pt] = sum1_reg[pt][i] + ACC_W'(v_sh[2*i + pt]);
            end
            acc_next[6 + pt] = gt124_reg[pt];
        end
    end

    always_ff @(posedge aclk) begin
        if (core_en) begin
            for (int pt = 0; pt < 2; pt++) begin
                for (int i = 0; i < NUM_BETA; i++) begin
                    sum1_reg[pt][i] <= ACC_W'(gbt[pt][i]) + ACC_W'(hp[pt][i]);
                end
                gt124_reg[pt] <= ACC_W'(gt[pt]);
            end
            for (int k = 0; k < NUM_COMP; k++) acc_reg[k] <= acc_next[k];
            v125_reg <= v124_w;
        end
    end

    always_comb begin
        m_data_next = '0;
        sat_hi      = 1'b0;
        sat_lo      = 1'b0;
        for (int k = 0; k < NUM_COMP; k++) begin
            sat_hi = !acc_reg[k][ACC_W-1]
                   && (|acc_reg[k][ACC_W-2:COMP_W+FRAC_SHIFT-1]);
            sat_lo = acc_reg[k][ACC_W-1]
                   && !(&acc_reg[k][ACC_W-2:COMP_W+FRAC_SHIFT-1]);
            if (sl125_w) begin
                m_data_next[k*COMP_W +: COMP_W] = v125_reg[k*COMP_W +: COMP_W];
            end else if (sat_hi) begin
                m_data_next[k*COMP_W +: COMP_W] = OUT_MAX;
            end else if (sat_lo) begin
                m_data_next[k*COMP_W +: COMP_W] = OUT_MIN;
            end else begin
                m_data_next[k*COMP_W +: COMP_W] = acc_reg[k][FRAC_SHIFT +: COMP_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            m_data_reg <= m_data_next;
            m_user_reg <= sl125_w;
        end
    end

    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;
endmodule
